// ===== src/isu_pkg.sv =====
// ---------------------------------------------------------------------------
// Insertion sorter package
// Word types for the input and result channels and the sequencer states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isu_pkg;

  // Input word: one element of the run and its end-of-run mark
  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_word_t;

  // Result word: one sorted element with its flags
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_res;
    logic               overflow;
  } out_word_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

  // Sequencer states
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } isu_state_t;

endpackage

`default_nettype wire

// ===== src/isu_cell.sv =====
// ---------------------------------------------------------------------------
// Insertion sorter cell
// One slot of the sorted chain: compares the broadcast element against its
// entry, takes the neighbor's entry on insertion and the upper neighbor's
// entry while draining.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isu_cell #(
  parameter int VALUE_BITS = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire  isu_pkg::cell_ctrl_t   ctrl,
  input  wire  [VALUE_BITS-1:0]       new_val,
  // lower neighbor (smaller entries)
  input  wire                         prev_valid,
  input  wire                         prev_gt,
  input  wire  [VALUE_BITS-1:0]       prev_data,
  // upper neighbor (larger entries)
  input  wire                         next_valid,
  input  wire  [VALUE_BITS-1:0]       next_data,
  output logic                        valid,
  output logic                        gt,
  output logic [VALUE_BITS-1:0]       data
);

  logic                  valid_r;
  logic                  valid_nxt;
  logic [VALUE_BITS-1:0] data_r;
  logic [VALUE_BITS-1:0] data_nxt;

  // Entry is strictly larger than the new element: equal elements stay below
  assign gt = valid_r && ($signed(new_val) < $signed(data_r));

  // Pick the next entry: shift up, take the new element, or shift down
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctrl.drain) begin
      valid_nxt = next_valid;
      data_nxt  = next_data;
    end else if (ctrl.insert) begin
      if (prev_gt) begin
        valid_nxt = 1'b1;
        data_nxt  = prev_data;
      end else if (gt || (!valid_r && prev_valid)) begin
        valid_nxt = 1'b1;
        data_nxt  = new_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

`default_nettype wire

// ===== src/insertion_sorter_unit.sv =====
// ---------------------------------------------------------------------------
// Insertion sorter unit
// Sorts a run of signed elements in a systolic chain of cells and emits the
// run in ascending order after its last element.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and raise start; a word is taken at each edge with
//   start high and busy low. Each element is inserted into the chain as it
//   is taken, so a run streams in at one word per cycle.
//   A word with last set ends the run. The chain then drains one entry per
//   cycle toward cell 0, with busy high while it drains. Results appear in
//   the cycle after each drain step, each shown for exactly one cycle with
//   out_valid high; last_res marks the final one. The next run may start as
//   soon as busy falls, while the final result is still out.
//   At most MAX_ITEMS elements are held; further ones are dropped and every
//   result of that run carries overflow. A last word that is dropped still
//   starts the drain.
//   The receiver cannot stall: results must be taken when out_valid is high.
//   Reset empties the chain and clears the overflow flag; no sweep is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter_unit #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire isu_pkg::in_word_t  in_data,
  output logic                    out_valid,
  output isu_pkg::out_word_t      out_data
);

  isu_pkg::isu_state_t   state_r;
  isu_pkg::isu_state_t   state_nxt;
  isu_pkg::cell_ctrl_t   ctrl;
  logic                  accept;
  logic                  full;
  logic                  drain_done;
  logic                  dropped_r;
  logic                  dropped_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  isu_pkg::out_word_t    out_data_r;
  isu_pkg::out_word_t    out_data_nxt;
  logic [63:0]           in_ext;
  logic [63:0]           head_ext;
  logic [VALUE_BITS-1:0] new_val;

  logic                  cell_valid [MAX_ITEMS];
  logic                  cell_gt    [MAX_ITEMS];
  logic [VALUE_BITS-1:0] cell_data  [MAX_ITEMS];

  // Read the element as a VALUE_BITS-wide two's complement number
  assign in_ext  = {32'd0, in_data.value};
  assign new_val = in_ext[VALUE_BITS-1:0];

  assign accept     = start && !busy;
  assign full       = cell_valid[MAX_ITEMS-1];
  assign drain_done = !cell_valid[1];

  // Build the chain
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                  p_valid;
    logic                  p_gt;
    logic [VALUE_BITS-1:0] p_data;
    logic                  n_valid;
    logic [VALUE_BITS-1:0] n_data;

    if (i == 0) begin : g_first
      assign p_valid = 1'b1;
      assign p_gt    = 1'b0;
      assign p_data  = new_val;
    end else begin : g_mid
      assign p_valid = cell_valid[i-1];
      assign p_gt    = cell_gt[i-1];
      assign p_data  = cell_data[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_top
      assign n_valid = 1'b0;
      assign n_data  = cell_data[i];
    end else begin : g_low
      assign n_valid = cell_valid[i+1];
      assign n_data  = cell_data[i+1];
    end

    isu_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_val    (new_val),
      .prev_valid (p_valid),
      .prev_gt    (p_gt),
      .prev_data  (p_data),
      .next_valid (n_valid),
      .next_data  (n_data),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i]),
      .data       (cell_data[i])
    );
  end

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      isu_pkg::ST_FILL: begin
        if (accept && in_data.last) begin
          state_nxt = isu_pkg::ST_DRAIN;
        end
      end
      isu_pkg::ST_DRAIN: begin
        if (drain_done) begin
          state_nxt = isu_pkg::ST_FILL;
        end
      end
      default: state_nxt = isu_pkg::ST_FILL;
    endcase
  end

  // Decode chain commands and the handshake
  always_comb begin
    busy        = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.drain  = 1'b0;
    unique case (state_r)
      isu_pkg::ST_FILL: begin
        ctrl.insert = start && !full;
      end
      isu_pkg::ST_DRAIN: begin
        busy       = 1'b1;
        ctrl.drain = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Track dropped elements for the run
  always_comb begin
    dropped_nxt = dropped_r;
    if (accept && full) begin
      dropped_nxt = 1'b1;
    end else if (ctrl.drain && drain_done) begin
      dropped_nxt = 1'b0;
    end
  end

  // Register the head of the chain as the result word
  assign head_ext = {{(64 - VALUE_BITS){1'b0}}, cell_data[0]};

  always_comb begin
    out_valid_nxt             = ctrl.drain;
    out_data_nxt.sorted_value = head_ext[31:0];
    out_data_nxt.last_res     = drain_done;
    out_data_nxt.overflow     = dropped_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isu_pkg::ST_FILL;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// Insertion sorter unit testbench
// Streams runs of signed elements into the sorter and checks every sorted
// word against an in-bench insertion-sort predictor. Opens with a table of
// directed runs, then fills the store past capacity, then sends random runs
// with random gaps and occasional pauses until every result has drained.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int CAPACITY   = 64;
  localparam int IDLE_LIMIT = 1000;
  localparam int RAND_ITEMS = 32;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  // One directed row: the word to send, and a hand-written result for
  // single-element runs whose output is plain at a glance
  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
    logic               pinned;
    isu_pkg::out_word_t want;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  isu_pkg::in_word_t  in_data;
  logic               out_valid;
  isu_pkg::out_word_t out_data;

  // Sorting predictor state
  logic signed [31:0] held [CAPACITY];
  int                 held_count;
  logic               run_dropped;
  isu_pkg::out_word_t sorted_q [$];

  // Hand-written expectation for the next accepted word
  logic               pin_armed;
  isu_pkg::out_word_t pin_word;

  int        fail_count;
  int        idle_cycles;
  stim_row_t stim_rows [$];

  insertion_sorter_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // 50 MHz clock
  always #10 clk = ~clk;

  // Insert one element after any equal entries; emit the run on last
  task automatic sort_take(input isu_pkg::in_word_t w);
    int                 pos;
    isu_pkg::out_word_t r;
    if (held_count < CAPACITY) begin
      pos = held_count;
      while (pos > 0 && held[pos - 1] > w.value) begin
        held[pos] = held[pos - 1];
        pos--;
      end
      held[pos] = w.value;
      held_count++;
    end else begin
      run_dropped = 1'b1;
    end
    if (w.last) begin
      if (pin_armed) begin
        sorted_q.push_back(pin_word);
      end else begin
        for (int k = 0; k < held_count; k++) begin
          r.sorted_value = held[k];
          r.last_res     = (k == held_count - 1);
          r.overflow     = run_dropped;
          sorted_q.push_back(r);
        end
      end
      held_count  = 0;
      run_dropped = 1'b0;
    end
    pin_armed = 1'b0;
  endtask

  // Compare one result word with the oldest expectation
  task automatic sorted_check(input isu_pkg::out_word_t got);
    isu_pkg::out_word_t exp_w;
    if (sorted_q.size() == 0) begin
      $error("unexpected result word: sorted_value %0d last_res %0b overflow %0b",
             got.sorted_value, got.last_res, got.overflow);
      fail_count++;
    end else begin
      exp_w = sorted_q.pop_front();
      if (got.sorted_value !== exp_w.sorted_value) begin
        $error("sorted_value: expected %0d, got %0d", exp_w.sorted_value, got.sorted_value);
        fail_count++;
      end
      if (got.last_res !== exp_w.last_res) begin
        $error("last_res: expected %0b, got %0b", exp_w.last_res, got.last_res);
        fail_count++;
      end
      if (got.overflow !== exp_w.overflow) begin
        $error("overflow: expected %0b, got %0b", exp_w.overflow, got.overflow);
        fail_count++;
      end
    end
  endtask

  // Check results, predict accepted words and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sorted_check(out_data);
      if (start && !busy) sort_take(in_data);
      if (out_valid || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  function automatic stim_row_t mk_row(input logic signed [31:0] v, input logic l,
                                       input logic pin);
    stim_row_t row;
    row.value             = v;
    row.last              = l;
    row.pinned            = pin;
    row.want.sorted_value = v;
    row.want.last_res     = 1'b1;
    row.want.overflow     = 1'b0;
    return row;
  endfunction

  // Mix of extremes, small values that collide, and full-range values
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    if (sel <= 3) return int'($urandom_range(0, 8)) - 4;
    return $urandom;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one word at the falling edge and hold it until taken
  task automatic send_word(input logic signed [31:0] v, input logic l);
    in_data.value = v;
    in_data.last  = l;
    start         = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_idle(input int cycles);
    if (cycles > 0) begin
      start = 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic drain_wait();
    start = 1'b0;
    while (sorted_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int        sent;
    int        run_len;
    bit        burst;
    stim_row_t row;

    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    held_count  = 0;
    run_dropped = 1'b0;
    pin_armed   = 1'b0;
    pin_word    = '0;
    fail_count  = 0;
    idle_cycles = 0;

    // Single-element runs: extremes, zero and minus one
    stim_rows.push_back(mk_row(VAL_MIN, 1'b1, 1'b1));
    stim_rows.push_back(mk_row(VAL_MAX, 1'b1, 1'b1));
    stim_rows.push_back(mk_row(32'sd0,  1'b1, 1'b1));
    stim_rows.push_back(mk_row(-32'sd1, 1'b1, 1'b1));
    // Duplicates and both extremes in one run
    stim_rows.push_back(mk_row(32'sd7,  1'b0, 1'b0));
    stim_rows.push_back(mk_row(-32'sd3, 1'b0, 1'b0));
    stim_rows.push_back(mk_row(32'sd7,  1'b0, 1'b0));
    stim_rows.push_back(mk_row(VAL_MAX, 1'b0, 1'b0));
    stim_rows.push_back(mk_row(VAL_MIN, 1'b0, 1'b0));
    stim_rows.push_back(mk_row(32'sd0,  1'b0, 1'b0));
    stim_rows.push_back(mk_row(-32'sd3, 1'b1, 1'b0));
    // Descending run shifts every entry on each insert
    stim_rows.push_back(mk_row(32'sd5,  1'b0, 1'b0));
    stim_rows.push_back(mk_row(32'sd4,  1'b0, 1'b0));
    stim_rows.push_back(mk_row(32'sd3,  1'b0, 1'b0));
    stim_rows.push_back(mk_row(32'sd2,  1'b0, 1'b0));
    stim_rows.push_back(mk_row(32'sd1,  1'b1, 1'b0));
    // Ascending run appends at the top
    stim_rows.push_back(mk_row(32'sd1,  1'b0, 1'b0));
    stim_rows.push_back(mk_row(32'sd2,  1'b0, 1'b0));
    stim_rows.push_back(mk_row(32'sd3,  1'b1, 1'b0));
    // Alternating bit patterns
    stim_rows.push_back(mk_row(32'sh5555_5555, 1'b0, 1'b0));
    stim_rows.push_back(mk_row(32'shAAAA_AAAA, 1'b1, 1'b0));

    // Hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      pin_armed = row.pinned;
      pin_word  = row.want;
      send_word(row.value, row.last);
      hold_idle(pick_gap());
    end
    drain_wait();

    // Fill past capacity: drop one plain word, then drop the last word too
    for (int i = 0; i < CAPACITY + 2; i++) begin
      send_word(pick_value(), i == CAPACITY + 1);
    end
    hold_idle(1);

    // Random short runs
    sent = 0;
    while (sent < RAND_ITEMS) begin
      run_len = $urandom_range(1, 8);
      burst   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < run_len; i++) begin
        send_word(pick_value(), i == run_len - 1);
        if (!burst) hold_idle(pick_gap());
      end
      sent += run_len;
      if ($urandom_range(0, 7) == 0) drain_wait();
    end

    // Let the last run drain, then watch for stray words
    drain_wait();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
